// ----- rtl/cso_pkg.sv -----
// shared types, constants and command table for the co2 sensor poller
package cso_pkg;

   localparam int FRAME_BYTES = 9;
   localparam int BEAT_W      = $clog2(FRAME_BYTES);
   localparam int CFG_W       = 16;
   localparam int CSR_IDX_W   = 2;
   localparam int QUEUE_DEPTH = 2;

   // input item kinds
   localparam logic KIND_TICK = 1'b0;
   localparam logic KIND_BYTE = 1'b1;

   // result beat kinds
   localparam logic OUT_CMD    = 1'b0;
   localparam logic OUT_REPORT = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_POLL_INTERVAL    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RESPONSE_TIMEOUT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RECOVERY_DELAY   = 2'd2;

   localparam logic [CFG_W-1:0] POLL_INTERVAL_RST    = 16'd5000;
   localparam logic [CFG_W-1:0] RESPONSE_TIMEOUT_RST = 16'd500;
   localparam logic [CFG_W-1:0] RECOVERY_DELAY_RST   = 16'd1000;

   // frame constants
   localparam logic [7:0] FRAME_START = 8'hFF;
   localparam logic [7:0] CMD_READ    = 8'h86;
   localparam logic [7:0] CMD_ADDR    = 8'h01;
   localparam logic [7:0] CMD_CHECK   = 8'h79;
   localparam logic [8:0] TEMP_OFFSET = 9'd40;

   localparam logic [BEAT_W-1:0] LAST_BEAT = BEAT_W'(FRAME_BYTES - 1);

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_CHECKSUM = 2'd1,
      STAT_HEADER   = 2'd2,
      STAT_TIMEOUT  = 2'd3
   } status_type;

   // one unit of work handed from the front to the back
   typedef struct packed {
      logic              is_report;
      status_type        status;
      logic [15:0]       ppm;
      logic signed [8:0] temperature;
   } job_type;

   // read command: FF 01 86 00 00 00 00 00 79
   function automatic logic [7:0] cmd_byte(input logic [BEAT_W-1:0] idx);
      logic [7:0] b;
      case (idx)
         4'd0:    b = FRAME_START;
         4'd1:    b = CMD_ADDR;
         4'd2:    b = CMD_READ;
         4'd8:    b = CMD_CHECK;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

// ----- rtl/co2_sensor_uart_poller.sv -----
// top level of the co2 sensor uart poller
//
//  channel  ports                        beat carries
//  -------  ---------------------------  ----------------------------------------
//  req      req_valid / req_ready        one ms tick or one received uart byte
//  rsp      rsp_valid / rsp_ready        one command byte or one measurement report
//  csr      csr_we, csr_index, csr_wdata write of poll, timeout or recovery register
//
// the front takes one req beat per cycle while the job queue has room; each beat
// updates the timers or the reply collector in that cycle and may queue one job
// the back turns a poll job into 9 command beats and a finished read into 1 report
// beat, one per cycle unless rsp stalls, via the queue slot and output register
// reset is synchronous and clears all control state; there is no clearing pass
// a stalled rsp side fills the 2-entry job queue, then req_ready drops
module co2_sensor_uart_poller #(
   parameter int TIMER_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_kind,
   input  logic [7:0]                     req_rx_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_out_kind,
   output logic [7:0]                     rsp_tx_byte,
   output logic                           rsp_last,
   output logic [1:0]                     rsp_status,
   output logic [15:0]                    rsp_ppm,
   output logic signed [8:0]              rsp_temperature,
   input  logic                           csr_we,
   input  logic [cso_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [cso_pkg::CFG_W-1:0]      csr_wdata
);
   import cso_pkg::*;

   // configuration registers
   logic [CFG_W-1:0] poll_interval_ff;
   logic [CFG_W-1:0] response_timeout_ff;
   logic [CFG_W-1:0] recovery_delay_ff;

   // front to queue to back
   job_type push_job, head_job;
   logic    job_push, job_pop, queue_empty, queue_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         poll_interval_ff    <= POLL_INTERVAL_RST;
         response_timeout_ff <= RESPONSE_TIMEOUT_RST;
         recovery_delay_ff   <= RECOVERY_DELAY_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_POLL_INTERVAL:    poll_interval_ff    <= csr_wdata;
            CSR_RESPONSE_TIMEOUT: response_timeout_ff <= csr_wdata;
            CSR_RECOVERY_DELAY:   recovery_delay_ff   <= csr_wdata;
            default: ;  // unmapped index, write ignored
         endcase
      end
   end

   // classify beats, run the timers and check the reply frame
   cso_front #(
      .TIMER_BITS (TIMER_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_kind         (req_kind),
      .req_rx_byte      (req_rx_byte),
      .req_ready        (req_ready),
      .poll_interval    (poll_interval_ff),
      .response_timeout (response_timeout_ff),
      .recovery_delay   (recovery_delay_ff),
      .queue_full       (queue_full),
      .job_push         (job_push),
      .job              (push_job)
   );

   // decouples front and back so each can stall on its own
   cso_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (job_push),
      .job_in  (push_job),
      .pop     (job_pop),
      .job_out (head_job),
      .empty   (queue_empty),
      .full    (queue_full)
   );

   // expand jobs into rsp beats
   cso_back u_back (
      .clock           (clock),
      .reset           (reset),
      .job             (head_job),
      .queue_empty     (queue_empty),
      .pop             (job_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_kind    (rsp_out_kind),
      .rsp_tx_byte     (rsp_tx_byte),
      .rsp_last        (rsp_last),
      .rsp_status      (rsp_status),
      .rsp_ppm         (rsp_ppm),
      .rsp_temperature (rsp_temperature)
   );

   // a job is never pushed into a full queue
   assert property (@(posedge clock) disable iff (reset) job_push |-> !queue_full)
      else $error("job pushed into full queue");

   // every report beat closes its burst
   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid && (rsp_out_kind == OUT_REPORT) |-> rsp_last)
      else $error("report beat without last");

   // the closing command beat is the checksum byte
   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid && (rsp_out_kind == OUT_CMD) && rsp_last
                    |-> (rsp_tx_byte == CMD_CHECK))
      else $error("command burst ends on wrong byte");

   // nothing is offered in the cycle after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp beat right after reset");

endmodule

// ----- rtl/cso_front.sv -----
// front end: timers, reply collection and frame check, emits jobs
module cso_front #(
   parameter int TIMER_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_kind,
   input  logic [7:0]                  req_rx_byte,
   output logic                        req_ready,
   input  logic [cso_pkg::CFG_W-1:0]   poll_interval,
   input  logic [cso_pkg::CFG_W-1:0]   response_timeout,
   input  logic [cso_pkg::CFG_W-1:0]   recovery_delay,
   input  logic                        queue_full,
   output logic                        job_push,
   output cso_pkg::job_type            job
);
   import cso_pkg::*;

   localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
   localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

   logic                  waiting_ff, waiting_in;
   logic                  add_recovery_ff, add_recovery_in;
   logic [TIMER_BITS-1:0] since_read_ff, since_read_in;
   logic [TIMER_BITS-1:0] since_cmd_ff, since_cmd_in;
   logic [3:0]            byte_count_ff, byte_count_in;
   logic [7:0]            sum_ff, sum_in;
   logic [15:0]           good_ppm_ff, good_ppm_in;
   logic signed [8:0]     good_temp_ff, good_temp_in;
   logic [7:0]            reply_ff [FRAME_BYTES-1];

   logic                  accept;
   logic [TIMER_BITS-1:0] since_read_inc, since_cmd_inc;
   logic [CMP_W:0]        threshold;
   logic                  poll_due, timed_out;
   logic                  header_ok, check_ok;
   logic                  store_byte;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   assign since_read_inc = (since_read_ff == TIMER_MAX) ? since_read_ff : since_read_ff + 1'b1;
   assign since_cmd_inc  = (since_cmd_ff == TIMER_MAX) ? since_cmd_ff : since_cmd_ff + 1'b1;

   // thresholds beyond the timer range fire at saturation
   assign threshold = {1'b0, CMP_W'(poll_interval)}
                    + {1'b0, add_recovery_ff ? CMP_W'(recovery_delay) : CMP_W'(0)};
   assign poll_due  = ({1'b0, CMP_W'(since_read_inc)} >= threshold)
                    || (since_read_inc == TIMER_MAX);
   assign timed_out = (CMP_W'(since_cmd_inc) > CMP_W'(response_timeout))
                    || (since_cmd_inc == TIMER_MAX);

   assign header_ok  = (reply_ff[0] == FRAME_START) && (reply_ff[1] == CMD_READ);
   assign check_ok   = (8'(8'h00 - sum_ff) == req_rx_byte);
   assign store_byte = accept && (req_kind == KIND_BYTE) && waiting_ff
                    && (byte_count_ff < 4'(FRAME_BYTES - 1));

   always_comb begin
      waiting_in      = waiting_ff;
      add_recovery_in = add_recovery_ff;
      since_read_in   = since_read_ff;
      since_cmd_in    = since_cmd_ff;
      byte_count_in   = byte_count_ff;
      sum_in          = sum_ff;
      good_ppm_in     = good_ppm_ff;
      good_temp_in    = good_temp_ff;
      job_push        = 1'b0;
      job             = '0;
      if (accept) begin
         case (req_kind)
            KIND_TICK: begin
               if (!waiting_ff) begin
                  since_read_in = since_read_inc;
                  if (poll_due) begin
                     job_push        = 1'b1;
                     job.is_report   = OUT_CMD;
                     waiting_in      = 1'b1;
                     since_cmd_in    = '0;
                     byte_count_in   = '0;
                     add_recovery_in = 1'b0;
                  end
               end else begin
                  since_cmd_in = since_cmd_inc;
                  if (timed_out) begin
                     job_push        = 1'b1;
                     job.is_report   = OUT_REPORT;
                     job.status      = STAT_TIMEOUT;
                     job.ppm         = good_ppm_ff;
                     job.temperature = good_temp_ff;
                     waiting_in      = 1'b0;
                     since_read_in   = '0;
                     add_recovery_in = 1'b1;
                     byte_count_in   = '0;
                  end
               end
            end
            KIND_BYTE: begin
               if (waiting_ff) begin
                  byte_count_in = byte_count_ff + 4'd1;
                  // running sum over bytes one to seven
                  if (byte_count_ff == 4'd0) begin
                     sum_in = '0;
                  end else if (byte_count_ff < 4'(FRAME_BYTES - 1)) begin
                     sum_in = sum_ff + req_rx_byte;
                  end
                  if (byte_count_ff == 4'(FRAME_BYTES - 1)) begin
                     job_push        = 1'b1;
                     job.is_report   = OUT_REPORT;
                     waiting_in      = 1'b0;
                     since_read_in   = '0;
                     byte_count_in   = '0;
                     add_recovery_in = 1'b0;
                     if (!header_ok) begin
                        job.status      = STAT_HEADER;
                        add_recovery_in = 1'b1;
                     end else if (!check_ok) begin
                        job.status = STAT_CHECKSUM;
                     end else begin
                        job.status   = STAT_OK;
                        good_ppm_in  = {reply_ff[2], reply_ff[3]};
                        good_temp_in = $signed({1'b0, reply_ff[4]} - TEMP_OFFSET);
                     end
                     job.ppm         = good_ppm_in;
                     job.temperature = good_temp_in;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         waiting_ff      <= 1'b0;
         add_recovery_ff <= 1'b0;
         since_read_ff   <= '0;
         since_cmd_ff    <= '0;
         byte_count_ff   <= '0;
         sum_ff          <= '0;
         good_ppm_ff     <= '0;
         good_temp_ff    <= '0;
      end else begin
         waiting_ff      <= waiting_in;
         add_recovery_ff <= add_recovery_in;
         since_read_ff   <= since_read_in;
         since_cmd_ff    <= since_cmd_in;
         byte_count_ff   <= byte_count_in;
         sum_ff          <= sum_in;
         good_ppm_ff     <= good_ppm_in;
         good_temp_ff    <= good_temp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_byte) begin
         reply_ff[byte_count_ff[2:0]] <= req_rx_byte;
      end
   end

endmodule

// ----- rtl/cso_queue.sv -----
// short job queue between front and back
module cso_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cso_pkg::job_type job_in,
   input  logic             pop,
   output cso_pkg::job_type job_out,
   output logic             empty,
   output logic             full
);
   import cso_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [PTR_W:0]   DEPTH_CNT = (PTR_W + 1)'(QUEUE_DEPTH);

   job_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;
   logic             do_push, do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == DEPTH_CNT);
   assign job_out = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= job_in;
      end
   end

endmodule

// ----- rtl/cso_back.sv -----
// back end: expands jobs into result beats behind an output register
module cso_back (
   input  logic             clock,
   input  logic             reset,
   input  cso_pkg::job_type job,
   input  logic             queue_empty,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic             rsp_out_kind,
   output logic [7:0]       rsp_tx_byte,
   output logic             rsp_last,
   output logic [1:0]       rsp_status,
   output logic [15:0]      rsp_ppm,
   output logic signed [8:0] rsp_temperature
);
   import cso_pkg::*;

   logic              busy_ff, busy_in;
   logic [BEAT_W-1:0] beat_ff, beat_in;
   logic              valid_ff, valid_in;
   logic              kind_ff, kind_in;
   logic [7:0]        tx_ff, tx_in;
   logic              last_ff, last_in;
   logic [1:0]        status_ff, status_in;
   logic [15:0]       ppm_ff, ppm_in;
   logic signed [8:0] temp_ff, temp_in;
   logic              out_free, load;

   assign out_free = !valid_ff || rsp_ready;
   assign load     = out_free && (busy_ff || !queue_empty);

   always_comb begin
      busy_in   = busy_ff;
      beat_in   = beat_ff;
      pop       = 1'b0;
      kind_in   = kind_ff;
      tx_in     = tx_ff;
      last_in   = last_ff;
      status_in = status_ff;
      ppm_in    = ppm_ff;
      temp_in   = temp_ff;
      valid_in  = load ? 1'b1 : (valid_ff && !rsp_ready);
      if (out_free) begin
         if (busy_ff) begin
            // rest of a command burst
            kind_in   = OUT_CMD;
            tx_in     = cmd_byte(beat_ff);
            last_in   = (beat_ff == LAST_BEAT);
            status_in = STAT_OK;
            ppm_in    = '0;
            temp_in   = '0;
            beat_in   = beat_ff + 1'b1;
            busy_in   = (beat_ff != LAST_BEAT);
         end else if (!queue_empty) begin
            pop = 1'b1;
            if (job.is_report == OUT_REPORT) begin
               kind_in   = OUT_REPORT;
               tx_in     = '0;
               last_in   = 1'b1;
               status_in = job.status;
               ppm_in    = job.ppm;
               temp_in   = job.temperature;
            end else begin
               kind_in   = OUT_CMD;
               tx_in     = cmd_byte('0);
               last_in   = 1'b0;
               status_in = STAT_OK;
               ppm_in    = '0;
               temp_in   = '0;
               beat_in   = BEAT_W'(1);
               busy_in   = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         beat_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         beat_ff  <= beat_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      tx_ff     <= tx_in;
      last_ff   <= last_in;
      status_ff <= status_in;
      ppm_ff    <= ppm_in;
      temp_ff   <= temp_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_kind    = kind_ff;
   assign rsp_tx_byte     = tx_ff;
   assign rsp_last        = last_ff;
   assign rsp_status      = status_ff;
   assign rsp_ppm         = ppm_ff;
   assign rsp_temperature = temp_ff;

endmodule
